// ===== design/radical_inverse_generator_defines.svh =====
// Assertion macros shared by the radical inverse generator.
// Every check is clocked on clock and switched off while reset is high.
`ifndef RADICAL_INVERSE_GENERATOR_DEFINES_SVH
`define RADICAL_INVERSE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RIG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RIG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rig_pkg.sv =====
package rig_pkg;

   // Default widths of the index and of the result fraction.
   localparam int INDEX_BITS_DEF    = 31;
   localparam int FRACTION_BITS_DEF = 32;

   // The base is an 8-bit field; anything below two is treated as two.
   localparam int BASE_W   = 8;
   localparam int MIN_BASE = 2;

   // The digit divider consumes this many dividend bits per cycle.
   localparam int CHUNK_W = 8;

endpackage

// ===== design/rig_digit_div.sv =====
module rig_digit_div (
   input  logic [rig_pkg::BASE_W-1:0]  rem_in,
   input  logic [rig_pkg::CHUNK_W-1:0] bits_in,
   input  logic [rig_pkg::BASE_W-1:0]  base_in,
   output logic [rig_pkg::BASE_W-1:0]  rem_out,
   output logic [rig_pkg::CHUNK_W-1:0] quo_out
);
   import rig_pkg::*;

   // Restoring division of one chunk of the dividend by the base, most
   // significant bit first. The remainder always stays below the base.
   always_comb begin
      logic [BASE_W:0] part;
      part    = {1'b0, rem_in};
      quo_out = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         part = {part[BASE_W-1:0], bits_in[i]};
         if (part >= {1'b0, base_in}) begin
            part       = part - {1'b0, base_in};
            quo_out[i] = 1'b1;
         end
      end
      rem_out = part[BASE_W-1:0];
   end

endmodule

// ===== design/radical_inverse_generator.sv =====
// Each beat divides the index by the base in 8-bit chunks to take its digits, then scales
// the mirrored numerator into FRACTION_BITS result bits and moves them to the output.
// A new beat is taken only in idle, once the fraction is scaled and moved into the output
// register, even while that previous result still waits there to be taken.
// Reset is synchronous and active high; it empties the block and drops rsp_valid.
`include "radical_inverse_generator_defines.svh"

module radical_inverse_generator #(
   parameter int INDEX_BITS    = rig_pkg::INDEX_BITS_DEF,
   parameter int FRACTION_BITS = rig_pkg::FRACTION_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [INDEX_BITS-1:0]       req_index,
   input  logic [rig_pkg::BASE_W-1:0]  req_base,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [FRACTION_BITS-1:0]    rsp_fraction
);
   import rig_pkg::*;

   localparam int CHUNKS   = (INDEX_BITS + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W    = CHUNKS * CHUNK_W;
   localparam int CHUNK_IW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int ACC_W    = INDEX_BITS + BASE_W;
   localparam int FCNT_W   = $clog2(FRACTION_BITS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIGIT  = 2'd1;
   localparam logic [1:0] ST_SCALE  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [BASE_W-1:0]        base_ff, base_in;
   logic [PAD_W-1:0]         idx_ff, idx_in;
   logic [PAD_W-1:0]         quo_ff, quo_in;
   logic [BASE_W-1:0]        rem_ff, rem_in;
   logic [CHUNK_IW-1:0]      chunk_ff, chunk_in;
   logic                     start_ff, start_in;
   logic [ACC_W-1:0]         mir_ff, mir_in;
   logic [ACC_W-1:0]         pow_ff, pow_in;
   logic [FCNT_W-1:0]        bitcnt_ff, bitcnt_in;
   logic [FRACTION_BITS-1:0] frac_ff, frac_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FRACTION_BITS-1:0] rsp_fraction_ff, rsp_fraction_in;

   logic [CHUNK_IW-1:0]      chunk_top, chunk_sel;
   logic [CHUNK_W-1:0]       chunk_bits;
   logic [BASE_W-1:0]        rem_cur, div_rem;
   logic [CHUNK_W-1:0]       div_quo;
   logic [PAD_W-1:0]         quo_next;
   logic [ACC_W+BASE_W-1:0]  mir_prod, pow_prod;
   logic [ACC_W-1:0]         mir_mac;
   logic [ACC_W:0]           scale_dbl, scale_diff;
   logic                     scale_ge;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fraction = rsp_fraction_ff;

   // Pick the chunk to divide: the top non-zero chunk when a digit starts,
   // then the chunks below it in turn.
   always_comb begin
      chunk_top = '0;
      for (int c = 0; c < CHUNKS; c++) begin
         if (idx_ff[c*CHUNK_W +: CHUNK_W] != '0) begin
            chunk_top = CHUNK_IW'(c);
         end
      end
      chunk_sel  = start_ff ? chunk_top : chunk_ff;
      chunk_bits = '0;
      for (int c = 0; c < CHUNKS; c++) begin
         if (chunk_sel == CHUNK_IW'(c)) begin
            chunk_bits = idx_ff[c*CHUNK_W +: CHUNK_W];
         end
      end
      rem_cur = start_ff ? '0 : rem_ff;
   end

   rig_digit_div u_digit_div (
      .rem_in  (rem_cur),
      .bits_in (chunk_bits),
      .base_in (base_ff),
      .rem_out (div_rem),
      .quo_out (div_quo)
   );

   // Gather the quotient chunk by chunk.
   always_comb begin
      quo_next = start_ff ? '0 : quo_ff;
      for (int c = 0; c < CHUNKS; c++) begin
         if (chunk_sel == CHUNK_IW'(c)) begin
            quo_next[c*CHUNK_W +: CHUNK_W] = div_quo;
         end
      end
   end

   // Mirrored numerator and base power grow by one digit at the end of each division.
   assign mir_prod = mir_ff * base_ff;
   assign pow_prod = pow_ff * base_ff;
   assign mir_mac  = mir_prod[ACC_W-1:0] + ACC_W'(div_rem);

   // One bit of numerator * 2^FRACTION_BITS / power per cycle.
   assign scale_dbl  = {mir_ff, 1'b0};
   assign scale_diff = scale_dbl - {1'b0, pow_ff};
   assign scale_ge   = (scale_dbl >= {1'b0, pow_ff});

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      base_in         = base_ff;
      idx_in          = idx_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      chunk_in        = chunk_ff;
      start_in        = start_ff;
      mir_in          = mir_ff;
      pow_in          = pow_ff;
      bitcnt_in       = bitcnt_ff;
      frac_in         = frac_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_fraction_in = rsp_fraction_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in   = PAD_W'(req_index);
               base_in  = (req_base < BASE_W'(MIN_BASE)) ? BASE_W'(MIN_BASE) : req_base;
               mir_in   = '0;
               pow_in   = ACC_W'(1);
               start_in = 1'b1;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (start_ff && (idx_ff == '0)) begin
               bitcnt_in = FCNT_W'(FRACTION_BITS - 1);
               state_in  = ST_SCALE;
            end else begin
               start_in = 1'b0;
               rem_in   = div_rem;
               quo_in   = quo_next;
               chunk_in = chunk_sel - 1'b1;
               if (chunk_sel == '0) begin
                  idx_in   = quo_next;
                  mir_in   = mir_mac;
                  pow_in   = pow_prod[ACC_W-1:0];
                  start_in = 1'b1;
               end
            end
         end
         ST_SCALE: begin
            mir_in  = scale_ge ? scale_diff[ACC_W-1:0] : scale_dbl[ACC_W-1:0];
            frac_in = {frac_ff[FRACTION_BITS-2:0], scale_ge};
            if (bitcnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bitcnt_in = bitcnt_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_fraction_in = frac_ff;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      base_ff         <= base_in;
      idx_ff          <= idx_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      chunk_ff        <= chunk_in;
      start_ff        <= start_in;
      mir_ff          <= mir_in;
      pow_ff          <= pow_in;
      bitcnt_ff       <= bitcnt_in;
      frac_ff         <= frac_in;
      rsp_fraction_ff <= rsp_fraction_in;
   end

   // Checks on the sequencer and the datapath invariants.
   `RIG_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_DIGIT,
      "accepted beat did not start digit extraction")
   `RIG_ASSERT_NOW(a_base_floor, state_ff != ST_IDLE, base_ff >= BASE_W'(MIN_BASE),
      "working base below two")
   `RIG_ASSERT_NOW(a_pow_nonzero, state_ff != ST_IDLE, pow_ff != '0,
      "base power became zero")
   `RIG_ASSERT_NOW(a_scale_rem, state_ff == ST_SCALE, mir_ff < pow_ff,
      "scaling remainder not below the base power")
   `RIG_ASSERT_NOW(a_digit_rem, (state_ff == ST_DIGIT) && !start_ff, rem_ff < base_ff,
      "digit remainder not below the base")

endmodule
